// ===== src/tavs_pkg.sv =====
// ----------------------------------------------------------------------------
// tavs_pkg: shared types and constants for the tagged value store
// Widths, status and function codes, controller states and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package tavs_pkg;

  localparam int WORD_W    = 32;
  localparam int TYPE_W    = 8;
  localparam int PAYLOAD_W = 24;
  localparam int STATUS_W  = 2;
  localparam int SLOT_W    = 5;

  localparam int TOP_SLOT_DEF    = 31;
  localparam int BOTTOM_SLOT_DEF = 1;

  localparam logic [WORD_W-1:0] ERASED_WORD = {WORD_W{1'b1}};

  typedef enum logic [STATUS_W-1:0] {
    ST_OK            = 2'd0,
    ST_NOT_PERMITTED = 2'd1,
    ST_FULL          = 2'd2
  } status_e;

  typedef enum logic {
    FUNC_WRITE = 1'b0,
    FUNC_READ  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic start;     // item accepted: latch operands, read top slot
    logic step;      // check one slot, read the next one down
    logic load_out;  // move result into output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic reject;    // incoming item is a write while writes are locked
    logic scan_done; // current slot ends the scan
    logic out_free;  // output register can take a result this cycle
  } sts_t;

endpackage

`default_nettype wire

// ===== src/tavs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tavs_ctrl: sequencer for the tagged value store
// Accepts one item at a time, runs the slot scan and hands the result over
// to the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module tavs_ctrl (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  output logic              in_stall_o,
  input  wire tavs_pkg::sts_t sts_i,
  output tavs_pkg::cmd_t    cmd_o
);

  tavs_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tavs_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      tavs_pkg::S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = sts_i.reject ? tavs_pkg::S_DONE : tavs_pkg::S_SCAN;
        end
      end
      tavs_pkg::S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = tavs_pkg::S_DONE;
        end
      end
      tavs_pkg::S_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = tavs_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = tavs_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/tavs_dp.sv =====
// ----------------------------------------------------------------------------
// tavs_dp: datapath of the tagged value store
// Slot memory with per-slot valid bits, scan counter, result registers,
// output register and the mode register.
// ----------------------------------------------------------------------------
`default_nettype none

module tavs_dp #(
  parameter int TopSlot    = tavs_pkg::TOP_SLOT_DEF,
  parameter int BottomSlot = tavs_pkg::BOTTOM_SLOT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire tavs_pkg::cmd_t                cmd_i,
  output tavs_pkg::sts_t                     sts_o,
  input  wire logic                          func_i,
  input  wire logic [tavs_pkg::WORD_W-1:0]   write_word_i,
  input  wire logic [tavs_pkg::TYPE_W-1:0]   value_type_i,
  input  wire logic                          cfg_valid_i,
  input  wire logic                          cfg_data_i,
  input  wire logic                          out_stall_i,
  output logic                               out_valid_o,
  output logic [tavs_pkg::STATUS_W-1:0]      status_o,
  output logic [tavs_pkg::SLOT_W-1:0]        slot_index_o,
  output logic [tavs_pkg::WORD_W-1:0]        read_value_o
);

  localparam int Depth = TopSlot + 1;
  localparam int AddrW = $clog2(Depth);
  localparam int WordW = tavs_pkg::WORD_W;
  localparam int TypeW = tavs_pkg::TYPE_W;
  localparam int PayW  = tavs_pkg::PAYLOAD_W;

  logic [WordW-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;

  logic             mode_q;
  logic             func_q;
  logic [WordW-1:0] word_q;
  logic [TypeW-1:0] type_q;
  logic [AddrW-1:0] chk_q;
  logic [AddrW-1:0] rd_addr;
  logic [WordW-1:0] rd_word_q;
  logic             rd_vld_q;

  logic [tavs_pkg::STATUS_W-1:0] res_status_q;
  logic [tavs_pkg::SLOT_W-1:0]   res_slot_q;
  logic [WordW-1:0]              res_value_q;
  logic                          out_valid_q;

  logic erased;
  logic last;
  logic hit;
  logic wr_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i) begin
      mode_q <= cfg_data_i;
    end
  end

  assign erased = !rd_vld_q || (rd_word_q == tavs_pkg::ERASED_WORD);
  assign last   = (chk_q == AddrW'(BottomSlot));
  assign hit    = (rd_word_q[WordW-1 -: TypeW] == type_q);
  assign wr_en  = cmd_i.step && (func_q == tavs_pkg::FUNC_WRITE) && erased;

  assign sts_o.reject    = (func_i == tavs_pkg::FUNC_WRITE) && !mode_q;
  assign sts_o.scan_done = erased || last;
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // next slot down; slot zero never goes below itself
  always_comb begin
    if (cmd_i.start) begin
      rd_addr = AddrW'(TopSlot);
    end else if (chk_q == '0) begin
      rd_addr = '0;
    end else begin
      rd_addr = chk_q - 1'b1;
    end
  end

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[chk_q] <= word_q;
    end
    rd_word_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_q[chk_q] <= 1'b1;
      end
      rd_vld_q <= vld_q[rd_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      func_q     <= func_i;
      word_q     <= write_word_i;
      type_q     <= value_type_i;
      chk_q      <= AddrW'(TopSlot);
      res_slot_q <= '0;
      if (func_i == tavs_pkg::FUNC_READ) begin
        res_status_q <= tavs_pkg::ST_OK;
        res_value_q  <= tavs_pkg::ERASED_WORD;
      end else begin
        res_status_q <= mode_q ? tavs_pkg::ST_FULL : tavs_pkg::ST_NOT_PERMITTED;
        res_value_q  <= '0;
      end
    end else if (cmd_i.step) begin
      chk_q <= rd_addr;
      if (func_q == tavs_pkg::FUNC_WRITE) begin
        if (erased) begin
          res_status_q <= tavs_pkg::ST_OK;
          res_slot_q   <= tavs_pkg::SLOT_W'(chk_q);
        end
      end else if (!erased && hit) begin
        // lower slots are newer, so the last hit wins
        res_value_q <= {{(WordW-PayW){1'b0}}, rd_word_q[PayW-1:0]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o     <= res_status_q;
      slot_index_o <= res_slot_q;
      read_value_o <= res_value_q;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== src/tagged_append_only_value_store_core.sv =====
// ----------------------------------------------------------------------------
// tagged_append_only_value_store_core: one-time-programmable tagged store
// Append-only word store; all ones marks an empty slot. Writes fill the
// highest empty slot, reads return the payload of the newest matching type.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries func, write_word and
//   value_type. Output channel (out_valid_o / out_stall_i) returns status,
//   slot_index and read_value, one result per item, in order.
//   Config channel (cfg_valid_i / cfg_ready_o) sets validation_mode; it is
//   always ready and should be written only while the block is idle.
//   Scan: an item scans one slot per cycle from TopSlot down, stopping at
//   the first empty slot or at BottomSlot; a locked write skips the scan.
//   The slot memory has a registered read, and the next item is taken in
//   the cycle after the previous result is handed to the output register.
//   Reset clears the mode register and marks every slot empty through
//   per-slot valid bits; no clearing pass is needed.
//   A stalled result stays in the output register; a next item may be
//   accepted and scanned meanwhile, and it waits for the register to free.
// ----------------------------------------------------------------------------
`default_nettype none

module tagged_append_only_value_store_core #(
  parameter int TopSlot    = tavs_pkg::TOP_SLOT_DEF,
  parameter int BottomSlot = tavs_pkg::BOTTOM_SLOT_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic                          func_i,
  input  wire logic [tavs_pkg::WORD_W-1:0]   write_word_i,
  input  wire logic [tavs_pkg::TYPE_W-1:0]   value_type_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [tavs_pkg::STATUS_W-1:0]      status_o,
  output logic [tavs_pkg::SLOT_W-1:0]        slot_index_o,
  output logic [tavs_pkg::WORD_W-1:0]        read_value_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic                          cfg_data_i
);

  tavs_pkg::cmd_t cmd;
  tavs_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  tavs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  tavs_dp #(
    .TopSlot    (TopSlot),
    .BottomSlot (BottomSlot)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .func_i       (func_i),
    .write_word_i (write_word_i),
    .value_type_i (value_type_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .read_value_o (read_value_o)
  );

endmodule

`default_nettype wire
